@@ design/trg_pkg.sv @@
// Shared types and constants of the trapezoidal ramp generator.
`default_nettype none
package trg_pkg;

   localparam int DIVIDEND_W = 27;
   localparam int DIVISOR_W  = 26;
   localparam int DIV_STEPS  = DIVIDEND_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
   localparam int MUL_A_W    = 23;
   localparam int MUL_B_W    = 24;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int ACC_W      = 40;

   localparam logic       OP_START = 1'b0;
   localparam logic       OP_TICK  = 1'b1;

   localparam logic [1:0] CSR_TICK_PERIOD = 2'd0;
   localparam logic [1:0] CSR_RAMP_TIME   = 2'd1;
   localparam logic [1:0] CSR_MAX_SPEED   = 2'd2;

   localparam logic [9:0]  TICK_RESET  = 10'd10;
   localparam logic [15:0] RAMP_RESET  = 16'd500;
   localparam logic [15:0] SPEED_RESET = 16'd1000;

   localparam logic [10:0] MS_PER_S  = 11'd1000;
   localparam logic [10:0] FRAC_DIV  = 11'd2000;
   localparam logic [ACC_W-1:0] POS_SAT_LIMIT = 40'd131072000;

   // position = ((acc >> 4) * ceil(2^30 / 125)) >> 30, exact below POS_SAT_LIMIT
   localparam int                 POS_SHIFT   = 4;
   localparam int                 RECIP_SHIFT = 30;
   localparam logic [MUL_B_W-1:0] POS_RECIP   = 24'd8589935;

   typedef struct packed {
      logic        operation;
      logic [15:0] distance;
   } req_type;

   typedef struct packed {
      logic [15:0] position;
      logic [15:0] speed;
      logic        idle;
      logic [15:0] step_index;
   } rsp_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RDIV,
      ST_RWAIT,
      ST_SDIV,
      ST_SWAIT,
      ST_BMUL,
      ST_BNUM,
      ST_BDIV,
      ST_BWAIT,
      ST_FIN,
      ST_TMUL,
      ST_TACC,
      ST_PDIV,
      ST_PWAIT,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

@@ design/trapezoidal_ramp_generator.sv @@
// Top level of the trapezoidal ramp generator: sequencer, multiplier and state.
//
//  channel | ports                          | handshake
//  --------+--------------------------------+-------------------------------
//  request | req_valid req_ready req_data   | valid/ready, start or tick item
//  result  | rsp_valid rsp_ready rsp_data   | valid/ready, one item per request
//  config  | csr_wr_en csr_index csr_wdata  | write on enable, no wait
//
//  A start item holds the block until it is ready again: three passes of the shared
//  divider (load, 27 quotient steps, done) plus the multiply, end-index and output
//  steps; two passes when max_speed is zero.
//  A tick item steps through multiply, accumulate, reciprocal scale and output;
//  the scale's product step is skipped when the position saturates.
//  Reset is synchronous; the block then reports idle with the reset registers.
//  A result waiting on rsp_ready holds the sequencer in its last step.
`default_nettype none
module trapezoidal_ramp_generator (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire trg_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output trg_pkg::rsp_type      rsp_data,
   input  wire logic             csr_wr_en,
   input  wire logic [1:0]       csr_index,
   input  wire logic [15:0]      csr_wdata
);
   import trg_pkg::*;

   state_type state_ff, state_in;

   logic [9:0]  tick_cfg_ff;
   logic [15:0] ramp_cfg_ff;
   logic [15:0] vmax_cfg_ff;

   logic [15:0]          tick_count_ff, tick_count_in;
   logic [15:0]          ramp_end_ff, ramp_end_in;
   logic [15:0]          brake_ff, brake_in;
   logic [15:0]          final_ff, final_in;
   logic [15:0]          step_ff, step_in;
   logic [15:0]          dist_ff, dist_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [15:0]          cur_ff, cur_in;
   logic [15:0]          prev_ff, prev_in;
   logic                 idle_ff, idle_in;
   logic                 done_ff, done_in;
   logic [9:0]           tick_lat_ff, tick_lat_in;
   logic [DIVISOR_W-1:0] den_ff, den_in;
   logic [15:0]          pos_ff, pos_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [9:0]  tick_eff;
   logic        accept;
   logic        out_free;
   logic [16:0] next_count;
   logic [16:0] up_sum;
   logic [16:0] final_sum;
   logic [ACC_W:0] acc_sum;
   logic [16:0] speed_sum;

   div_req_type div_req;
   div_rsp_type div_rsp;

   trg_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign tick_eff  = (tick_cfg_ff == '0) ? 10'd1 : tick_cfg_ff;
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign next_count = {1'b0, tick_count_ff} + 17'd1;
   assign up_sum     = {1'b0, cur_ff} + {1'b0, step_ff};
   assign final_sum  = {1'b0, brake_ff} + {1'b0, ramp_end_ff};
   assign acc_sum    = {1'b0, acc_ff} + (ACC_W+1)'(prod_ff);
   assign speed_sum  = {1'b0, cur_ff} + {1'b0, prev_ff};
   assign prod_in    = mul_a * mul_b;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_data.operation == OP_START) ? ST_RDIV : ST_TMUL;
            end
         end
         ST_RDIV:  state_in = ST_RWAIT;
         ST_RWAIT: if (div_rsp.done) state_in = ST_SDIV;
         ST_SDIV:  state_in = ST_SWAIT;
         ST_SWAIT: if (div_rsp.done) state_in = ST_BMUL;
         ST_BMUL:  state_in = ST_BNUM;
         ST_BNUM:  state_in = ST_BDIV;
         ST_BDIV:  state_in = (den_ff == '0) ? ST_FIN : ST_BWAIT;
         ST_BWAIT: if (div_rsp.done) state_in = ST_FIN;
         ST_FIN:   state_in = ST_DONE;
         ST_TMUL:  state_in = ST_TACC;
         ST_TACC:  state_in = ST_PDIV;
         ST_PDIV:  state_in = (acc_ff >= POS_SAT_LIMIT) ? ST_DONE : ST_PWAIT;
         ST_PWAIT: state_in = ST_DONE;
         ST_DONE:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath controls
   always_comb begin
      tick_count_in = tick_count_ff;
      ramp_end_in   = ramp_end_ff;
      brake_in      = brake_ff;
      final_in      = final_ff;
      step_in       = step_ff;
      dist_in       = dist_ff;
      acc_in        = acc_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      idle_in       = idle_ff;
      done_in       = done_ff;
      tick_lat_in   = tick_lat_ff;
      den_in        = den_ff;
      pos_in        = pos_ff;
      mul_a         = '0;
      mul_b         = '0;
      div_req       = '0;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.operation == OP_START) begin
               dist_in       = req_data.distance;
               tick_count_in = '0;
               tick_lat_in   = tick_eff;
               cur_in        = '0;
               acc_in        = '0;
               pos_in        = '0;
               idle_in       = 1'b0;
            end else if (accept) begin
               prev_in       = cur_ff;
               tick_count_in = next_count[16] ? 16'hFFFF : next_count[15:0];
               done_in       = 1'b0;
               if (next_count <= {1'b0, ramp_end_ff}) begin
                  cur_in = up_sum[16] ? 16'hFFFF : up_sum[15:0];
               end else if (next_count <= {1'b0, brake_ff}) begin
                  cur_in = vmax_cfg_ff;
               end else if (next_count <= {1'b0, final_ff}) begin
                  cur_in = (cur_ff > step_ff) ? cur_ff - step_ff : 16'd0;
               end else begin
                  cur_in  = '0;
                  done_in = 1'b1;
               end
               idle_in = (next_count > {1'b0, final_ff});
            end
         end
         ST_RDIV: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIVIDEND_W'(ramp_cfg_ff);
            div_req.divisor  = DIVISOR_W'(tick_lat_ff);
         end
         ST_RWAIT: begin
            if (div_rsp.done) begin
               ramp_end_in = (div_rsp.quotient == '0) ? 16'd1 : div_rsp.quotient[15:0];
            end
         end
         ST_SDIV: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIVIDEND_W'(vmax_cfg_ff);
            div_req.divisor  = DIVISOR_W'(ramp_end_ff);
         end
         ST_SWAIT: begin
            if (div_rsp.done) begin
               step_in = div_rsp.quotient[15:0];
            end
         end
         ST_BMUL: begin
            mul_a = MUL_A_W'(vmax_cfg_ff);
            mul_b = MUL_B_W'(tick_lat_ff);
         end
         ST_BNUM: begin
            den_in = prod_ff[DIVISOR_W-1:0];
            mul_a  = MUL_A_W'(dist_ff);
            mul_b  = MUL_B_W'(MS_PER_S);
         end
         ST_BDIV: begin
            if (den_ff == '0) begin
               brake_in = 16'hFFFF;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = prod_ff[DIVIDEND_W-1:0];
               div_req.divisor  = den_ff;
            end
         end
         ST_BWAIT: begin
            if (div_rsp.done) begin
               brake_in = (div_rsp.quotient[DIVIDEND_W-1:16] != '0) ? 16'hFFFF
                        : div_rsp.quotient[15:0];
            end
         end
         ST_FIN: begin
            final_in = final_sum[16] ? 16'hFFFF : final_sum[15:0];
         end
         ST_TMUL: begin
            if (done_ff) begin
               mul_a = MUL_A_W'(dist_ff);
               mul_b = MUL_B_W'(FRAC_DIV);
            end else begin
               mul_a = MUL_A_W'(speed_sum);
               mul_b = MUL_B_W'(tick_lat_ff);
            end
         end
         ST_TACC: begin
            if (done_ff) begin
               acc_in = ACC_W'(prod_ff);
            end else begin
               acc_in = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
            end
         end
         ST_PDIV: begin
            if (acc_ff >= POS_SAT_LIMIT) begin
               pos_in = 16'hFFFF;
            end else begin
               mul_a = acc_ff[POS_SHIFT+MUL_A_W-1:POS_SHIFT];
               mul_b = POS_RECIP;
            end
         end
         ST_PWAIT: begin
            pos_in = prod_ff[RECIP_SHIFT+15:RECIP_SHIFT];
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.position   = pos_ff;
               rsp_data_in.speed      = cur_ff;
               rsp_data_in.idle       = idle_ff;
               rsp_data_in.step_index = tick_count_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tick_cfg_ff   <= TICK_RESET;
         ramp_cfg_ff   <= RAMP_RESET;
         vmax_cfg_ff   <= SPEED_RESET;
         tick_count_ff <= '0;
         ramp_end_ff   <= '0;
         brake_ff      <= '0;
         final_ff      <= '0;
         step_ff       <= '0;
         dist_ff       <= '0;
         acc_ff        <= '0;
         cur_ff        <= '0;
         prev_ff       <= '0;
         idle_ff       <= 1'b1;
         done_ff       <= 1'b0;
         tick_lat_ff   <= '0;
         pos_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tick_count_ff <= tick_count_in;
         ramp_end_ff   <= ramp_end_in;
         brake_ff      <= brake_in;
         final_ff      <= final_in;
         step_ff       <= step_in;
         dist_ff       <= dist_in;
         acc_ff        <= acc_in;
         cur_ff        <= cur_in;
         prev_ff       <= prev_in;
         idle_ff       <= idle_in;
         done_ff       <= done_in;
         tick_lat_ff   <= tick_lat_in;
         pos_ff        <= pos_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_TICK_PERIOD: tick_cfg_ff <= csr_wdata[9:0];
               CSR_RAMP_TIME:   ramp_cfg_ff <= csr_wdata;
               CSR_MAX_SPEED:   vmax_cfg_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
      den_ff      <= den_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

@@ design/trg_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module trg_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire trg_pkg::div_req_type div_req,
   output trg_pkg::div_rsp_type      div_rsp
);
   import trg_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  den_ff, den_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;

   always_comb begin
      trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff  = trial - {1'b0, den_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         den_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = diff[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule
`default_nettype wire

@@ bench/tb_trapezoidal_ramp_generator.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the trapezoidal ramp generator: model, drivers and checks.
module tb_trapezoidal_ramp_generator;
   import trg_pkg::*;

   typedef longint unsigned wide_type;

   localparam logic [1:0] CSR_UNUSED   = 2'd3;
   localparam wide_type   ACC_LIMIT    = 64'hFF_FFFF_FFFF;
   localparam wide_type   SAT16        = 64'd65535;
   localparam int         CYCLE_LIMIT  = 5000000;
   localparam int         RANDOM_ITEMS = 600;
   localparam int         SOAK_TICKS   = 40;

   class ramp_scoreboard;
      logic [9:0]  tick_reg;
      logic [15:0] ramp_reg;
      logic [15:0] speed_reg;
      wide_type    count, ramp_end, brake_at, final_at, step_size;
      wide_type    target, speed_now, tick_held, acc;
      logic        idle_now;
      rsp_type     expected_q[$];
      int          errors;

      function new();
         tick_reg  = TICK_RESET;
         ramp_reg  = RAMP_RESET;
         speed_reg = SPEED_RESET;
         count     = 0;
         ramp_end  = 0;
         brake_at  = 0;
         final_at  = 0;
         step_size = 0;
         target    = 0;
         speed_now = 0;
         tick_held = 0;
         acc       = 0;
         idle_now  = 1'b1;
         errors    = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [15:0] val);
         case (idx)
            CSR_TICK_PERIOD: tick_reg  = val[9:0];
            CSR_RAMP_TIME:   ramp_reg  = val;
            CSR_MAX_SPEED:   speed_reg = val;
            default: ;
         endcase
      endfunction

      function void note_request(req_type it);
         wide_type tick, vmax, r, b, f, denom, nxt, prev, sum;
         rsp_type  want;
         tick = (tick_reg == 10'd0) ? wide_type'(1) : wide_type'(tick_reg);
         vmax = wide_type'(speed_reg);
         if (it.operation == OP_START) begin
            target    = wide_type'(it.distance);
            count     = 0;
            tick_held = tick;
            r = wide_type'(ramp_reg) / tick;
            if (r == 0) r = 1;
            ramp_end  = r;
            step_size = vmax / r;
            denom = vmax * tick;
            if (denom == 0) b = SAT16;
            else b = target * wide_type'(MS_PER_S) / denom;
            if (b > SAT16) b = SAT16;
            brake_at = b;
            f = b + r;
            if (f > SAT16) f = SAT16;
            final_at  = f;
            speed_now = 0;
            acc       = 0;
            idle_now  = 1'b0;
         end else begin
            prev  = speed_now;
            nxt   = count + 1;
            count = (nxt > SAT16) ? SAT16 : nxt;
            if (nxt <= ramp_end) begin
               speed_now = speed_now + step_size;
               if (speed_now > SAT16) speed_now = SAT16;
            end else if (nxt <= brake_at) begin
               speed_now = vmax;
            end else if (nxt <= final_at) begin
               speed_now = (speed_now > step_size) ? speed_now - step_size : 0;
            end else begin
               speed_now = 0;
            end
            idle_now = (nxt > final_at);
            if (idle_now) begin
               acc = target * wide_type'(FRAC_DIV);
            end else begin
               sum = acc + (speed_now + prev) * tick_held;
               acc = (sum > ACC_LIMIT) ? ACC_LIMIT : sum;
            end
         end
         want.position   = (acc / wide_type'(FRAC_DIV) > SAT16) ? 16'hFFFF
                                                                : 16'(acc / wide_type'(FRAC_DIV));
         want.speed      = 16'(speed_now);
         want.idle       = idle_now;
         want.step_index = 16'(count);
         expected_q.push_back(want);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected item pos %0d speed %0d idle %0d step %0d",
                     $time, got.position, got.speed, got.idle, got.step_index);
            return;
         end
         want = expected_q.pop_front();
         if (got !== want) begin
            errors++;
            $display("%0t: pos/speed/idle/step expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                     $time, want.position, want.speed, want.idle, want.step_index,
                     got.position, got.speed, got.idle, got.step_index);
         end
      endfunction
   endclass

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = CSR_TICK_PERIOD;
   logic [15:0] csr_wdata = '0;

   bit             calm       = 1'b0;
   int             stall_left = 0;
   int             cycles     = 0;
   ramp_scoreboard sb;

   trapezoidal_ramp_generator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (calm || reset) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 99) < 12)
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                     : $urandom_range(1, 3);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
   end

   task automatic send_item(input logic op, input logic [15:0] trip);
      req_type it;
      int      gap;
      int      roll;
      it.operation = op;
      it.distance  = trip;
      gap = 0;
      if (!calm) begin
         roll = $urandom_range(0, 99);
         if (roll >= 90) gap = $urandom_range(10, 40);
         else if (roll >= 55) gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      sb.note_request(it);
   endtask

   task automatic run_ticks(input int n);
      repeat (n) send_item(OP_TICK, 16'($urandom));
   endtask

   // hold off the sender until every pending item has come back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.expected_q.size() != 0);
   endtask

   task automatic configure(input logic [15:0] tick_w, input logic [15:0] ramp_w,
                            input logic [15:0] speed_w);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_TICK_PERIOD;
      csr_wdata <= tick_w;
      @(posedge clock);
      csr_index <= CSR_RAMP_TIME;
      csr_wdata <= ramp_w;
      @(posedge clock);
      csr_index <= CSR_MAX_SPEED;
      csr_wdata <= speed_w;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.write_reg(CSR_TICK_PERIOD, tick_w);
      sb.write_reg(CSR_RAMP_TIME, ramp_w);
      sb.write_reg(CSR_MAX_SPEED, speed_w);
   endtask

   initial begin
      int          n_random;
      int          n;
      int          roll;
      wide_type    teff;
      wide_type    vt;
      wide_type    dist_w;
      wide_type    fin;
      logic [15:0] tick_w;
      logic [15:0] ramp_w;
      logic [15:0] speed_w;

      sb = new();
      n_random = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      run_ticks(2);
      drain();
      configure(16'd100, 16'd300, 16'd1000);
      send_item(OP_START, 16'd500);
      run_ticks(9);
      send_item(OP_START, 16'd100);
      run_ticks(5);
      drain();
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_UNUSED;
      csr_wdata <= 16'($urandom);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      configure(16'hFC00, 16'd0, 16'd0);
      send_item(OP_START, 16'hFFFF);
      run_ticks(2);
      drain();
      configure(16'd1, 16'hFFFF, 16'd1);
      send_item(OP_START, 16'hFFFF);
      run_ticks(1);

      // cruise at full speed: saturate the position
      drain();
      configure(16'd1000, 16'd0, 16'd0);
      send_item(OP_START, 16'hFFFF);
      drain();
      configure(16'd1000, 16'd0, 16'hFFFF);
      calm = 1'b1;
      run_ticks(SOAK_TICKS);
      calm = 1'b0;

      while (n_random < RANDOM_ITEMS) begin
         calm = ($urandom_range(0, 5) == 0);
         if ($urandom_range(0, 2) == 0) begin
            roll = $urandom_range(0, 9);
            if (roll == 0) tick_w = 16'd0;
            else if (roll == 1) tick_w = 16'd1000;
            else if (roll == 2) tick_w = 16'($urandom);
            else tick_w = 16'($urandom_range(1, 200));
            teff = (tick_w[9:0] == 10'd0) ? wide_type'(1) : wide_type'(tick_w[9:0]);
            if ($urandom_range(0, 7) == 0) begin
               ramp_w = 16'($urandom);
            end else begin
               vt = wide_type'($urandom_range(0, 10)) * teff
                    + wide_type'($urandom_range(0, 32'(teff - 1)));
               ramp_w = (vt > SAT16) ? 16'hFFFF : 16'(vt);
            end
            roll = $urandom_range(0, 19);
            if (roll == 0) speed_w = 16'd0;
            else if (roll == 1) speed_w = 16'hFFFF;
            else if (roll == 2) speed_w = 16'd1;
            else speed_w = 16'($urandom_range(1, 65535));
            drain();
            configure(tick_w, ramp_w, speed_w);
         end

         teff = (sb.tick_reg == 10'd0) ? wide_type'(1) : wide_type'(sb.tick_reg);
         vt = wide_type'(sb.speed_reg) * teff / 1000;
         if ($urandom_range(0, 7) == 0) begin
            dist_w = wide_type'($urandom_range(0, 65535));
         end else begin
            dist_w = wide_type'($urandom_range(0, 25)) * vt
                     + wide_type'($urandom_range(0, 32'(vt)));
            if (dist_w > SAT16) dist_w = SAT16;
         end
         send_item(OP_START, 16'(dist_w));
         n_random++;

         fin = sb.final_at;
         if ($urandom_range(0, 7) == 0) n = $urandom_range(0, (fin > 40) ? 40 : 32'(fin));
         else if (fin <= 45) n = 32'(fin) + $urandom_range(1, 3);
         else n = $urandom_range(10, 45);

         repeat (n) begin
            if ($urandom_range(0, 29) == 0) begin
               drain();
               configure(16'(sb.tick_reg), sb.ramp_reg, 16'($urandom_range(0, 65535)));
            end
            send_item(OP_TICK, 16'($urandom));
            n_random++;
         end
      end

      calm = 1'b0;
      drain();
      repeat (40) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

@@ sim.f @@
design/trg_pkg.sv
design/trg_div.sv
design/trapezoidal_ramp_generator.sv
bench/tb_trapezoidal_ramp_generator.sv
